// File: hw/rtl/cdq_pkg.sv
`default_nettype none
package cdq_pkg;

	localparam int unsigned CDQ_DEPTH = 128;
	localparam int unsigned WORD_W    = 32;

	// Command codes carried in a command beat.
	localparam logic [2:0] CMD_QUERY      = 3'd0;
	localparam logic [2:0] CMD_PUSH_FRONT = 3'd1;
	localparam logic [2:0] CMD_PUSH_BACK  = 3'd2;
	localparam logic [2:0] CMD_POP_FRONT  = 3'd3;
	localparam logic [2:0] CMD_POP_BACK   = 3'd4;

	// Status codes carried in a response beat.
	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_OVERFLOW  = 2'd1;
	localparam logic [1:0] ST_UNDERFLOW = 2'd2;

	// Operation broadcast to every cell of one chain.
	typedef enum logic [2:0] {
		OP_HOLD,
		OP_SHIFT_IN,
		OP_APPEND,
		OP_SHIFT_OUT,
		OP_DROP_LAST
	} cell_op_t;

	typedef struct packed {
		cell_op_t           op;
		logic [WORD_W-1:0]  word;
	} cell_ctl_t;

	typedef struct packed {
		logic [2:0]          command;
		logic signed [31:0]  push_value;
	} cmd_t;

	typedef struct packed {
		logic [1:0]          status;
		logic signed [31:0]  popped_value;
		logic                popped_valid;
		logic signed [31:0]  front_value;
		logic signed [31:0]  back_value;
		logic [7:0]          item_count;
		logic                is_empty;
		logic                is_full;
	} rsp_t;

endpackage
`default_nettype wire

// File: hw/rtl/cdq_cell.sv
`default_nettype none
module cdq_cell (
	input  wire                            clk,
	input  wire                            arst_n,
	input  cdq_pkg::cell_ctl_t             ctl,
	input  wire  [cdq_pkg::WORD_W-1:0]     prev_word,
	input  wire                            prev_valid,
	input  wire  [cdq_pkg::WORD_W-1:0]     next_word,
	input  wire                            next_valid,
	output logic [cdq_pkg::WORD_W-1:0]     word_q,
	output logic                           valid_q,
	output logic [cdq_pkg::WORD_W-1:0]     word_d
);
	import cdq_pkg::*;

	logic valid_d;

	// The neighbor toward the head is "prev", toward the tail is "next".
	always_comb begin
		word_d  = word_q;
		valid_d = valid_q;
		case (ctl.op)
			OP_SHIFT_IN: begin
				word_d  = prev_word;
				valid_d = prev_valid;
			end
			OP_APPEND: begin
				// Only the first empty cell takes the new word.
				if (!valid_q && prev_valid) begin
					word_d  = ctl.word;
					valid_d = 1'b1;
				end
			end
			OP_SHIFT_OUT: begin
				word_d  = next_word;
				valid_d = next_valid;
			end
			OP_DROP_LAST: begin
				if (valid_q && !next_valid) begin
					valid_d = 1'b0;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= valid_d;
		end
	end

	always_ff @(posedge clk) begin
		word_q <= word_d;
	end

endmodule
`default_nettype wire

// File: hw/rtl/cdq_chain.sv
`default_nettype none
module cdq_chain #(
	parameter int unsigned DEPTH = cdq_pkg::CDQ_DEPTH
) (
	input  wire                            clk,
	input  wire                            arst_n,
	input  cdq_pkg::cell_ctl_t             ctl,
	output logic [cdq_pkg::WORD_W-1:0]     head_word,
	output logic [cdq_pkg::WORD_W-1:0]     head_next
);
	import cdq_pkg::*;

	logic [WORD_W-1:0] word_q  [DEPTH];
	logic              valid_q [DEPTH];
	logic [WORD_W-1:0] word_d  [DEPTH];
	logic [WORD_W-1:0] prev_word  [DEPTH];
	logic              prev_valid [DEPTH];
	logic [WORD_W-1:0] next_word  [DEPTH];
	logic              next_valid [DEPTH];

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		// The head cell sees the incoming word as a full neighbor, and the
		// tail cell sees an empty one, so every cell follows the same rule.
		if (i == 0) begin : g_head
			assign prev_word[i]  = ctl.word;
			assign prev_valid[i] = 1'b1;
		end else begin : g_mid_p
			assign prev_word[i]  = word_q[i-1];
			assign prev_valid[i] = valid_q[i-1];
		end
		if (i == DEPTH-1) begin : g_tail
			assign next_word[i]  = '0;
			assign next_valid[i] = 1'b0;
		end else begin : g_mid_n
			assign next_word[i]  = word_q[i+1];
			assign next_valid[i] = valid_q[i+1];
		end

		cdq_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctl        (ctl),
			.prev_word  (prev_word[i]),
			.prev_valid (prev_valid[i]),
			.next_word  (next_word[i]),
			.next_valid (next_valid[i]),
			.word_q     (word_q[i]),
			.valid_q    (valid_q[i]),
			.word_d     (word_d[i])
		);
	end

	assign head_word = word_q[0];
	assign head_next = word_d[0];

endmodule
`default_nettype wire

// File: hw/rtl/circular_deque_top.sv
`default_nettype none
// Double-ended queue of up to DEPTH signed 32-bit words. Each command beat
// (query, push front, push back, pop front, pop back) gives exactly one
// response beat with the status, the popped word and the front word, back
// word and count after the command. A command is taken every cycle while the
// response register is free or being drained, and its response appears in
// the cycle after it is taken. The words live in two mirrored chains of
// DEPTH cells, one with the front word in its first cell and one with the
// back word in its first cell; every command only moves words between
// neighboring cells, which is what holds the rate at one command per cycle.
// The chains need no clearing after reset.
module circular_deque_top #(
	parameter int unsigned DEPTH = cdq_pkg::CDQ_DEPTH
) (
	input  wire             clk,
	input  wire             arst_n,
	input  wire             cmd_valid,
	output logic            cmd_stall,
	input  cdq_pkg::cmd_t   cmd_data,
	output logic            rsp_valid,
	input  wire             rsp_stall,
	output cdq_pkg::rsp_t   rsp_data
);
	import cdq_pkg::*;

	localparam int unsigned CntW = $clog2(DEPTH + 1);

	logic [CntW-1:0]   cnt_q;
	logic [CntW-1:0]   cnt_d;
	logic              rsp_valid_q;
	rsp_t              rsp_q;
	logic              accept;
	logic              full;
	logic              empty;
	logic              is_push;
	logic              is_pop;
	logic              at_front;
	logic              do_push;
	logic              do_pop;
	cell_ctl_t         ctl_f;
	cell_ctl_t         ctl_b;
	logic [WORD_W-1:0] front_word;
	logic [WORD_W-1:0] front_next;
	logic [WORD_W-1:0] back_word;
	logic [WORD_W-1:0] back_next;
	rsp_t              rsp_d;

	assign cmd_stall = rsp_valid_q & rsp_stall;
	assign accept    = cmd_valid & ~cmd_stall;
	assign full      = (cnt_q == CntW'(DEPTH));
	assign empty     = (cnt_q == '0);

	always_comb begin
		is_push  = 1'b0;
		is_pop   = 1'b0;
		at_front = 1'b0;
		unique case (cmd_data.command)
			CMD_PUSH_FRONT: begin
				is_push  = 1'b1;
				at_front = 1'b1;
			end
			CMD_PUSH_BACK: begin
				is_push = 1'b1;
			end
			CMD_POP_FRONT: begin
				is_pop   = 1'b1;
				at_front = 1'b1;
			end
			CMD_POP_BACK: begin
				is_pop = 1'b1;
			end
			default: begin
			end
		endcase
	end

	assign do_push = accept & is_push & ~full;
	assign do_pop  = accept & is_pop & ~empty;

	// The front chain treats the front end as its head; the back chain is its
	// mirror image, so a front-end operation on one is a tail operation on the
	// other.
	always_comb begin
		ctl_f.word = cmd_data.push_value;
		ctl_b.word = cmd_data.push_value;
		ctl_f.op   = OP_HOLD;
		ctl_b.op   = OP_HOLD;
		if (do_push) begin
			ctl_f.op = at_front ? OP_SHIFT_IN : OP_APPEND;
			ctl_b.op = at_front ? OP_APPEND : OP_SHIFT_IN;
		end else if (do_pop) begin
			ctl_f.op = at_front ? OP_SHIFT_OUT : OP_DROP_LAST;
			ctl_b.op = at_front ? OP_DROP_LAST : OP_SHIFT_OUT;
		end
	end

	cdq_chain #(
		.DEPTH (DEPTH)
	) u_front_chain (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl_f),
		.head_word (front_word),
		.head_next (front_next)
	);

	cdq_chain #(
		.DEPTH (DEPTH)
	) u_back_chain (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl_b),
		.head_word (back_word),
		.head_next (back_next)
	);

	always_comb begin
		cnt_d = cnt_q;
		if (do_push) begin
			cnt_d = cnt_q + CntW'(1);
		end else if (do_pop) begin
			cnt_d = cnt_q - CntW'(1);
		end
	end

	always_comb begin
		rsp_d.status = ST_OK;
		if (is_push && full) begin
			rsp_d.status = ST_OVERFLOW;
		end else if (is_pop && empty) begin
			rsp_d.status = ST_UNDERFLOW;
		end
		rsp_d.popped_valid = is_pop & ~empty;
		rsp_d.popped_value = '0;
		if (is_pop && !empty) begin
			rsp_d.popped_value = at_front ? front_word : back_word;
		end
		rsp_d.front_value = (cnt_d == '0) ? '0 : front_next;
		rsp_d.back_value  = (cnt_d == '0) ? '0 : back_next;
		rsp_d.item_count  = 8'(cnt_d);
		rsp_d.is_empty    = (cnt_d == '0);
		rsp_d.is_full     = (cnt_d == CntW'(DEPTH));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			cnt_q <= cnt_d;
			if (accept) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp_data  = rsp_q;

endmodule
`default_nettype wire
